@@ rtl/core/slpid_pkg.sv @@
`default_nettype none

package slpid_pkg;

  // parameter defaults
  localparam int PERIOD_MIN_DEF       = 60000;
  localparam int PERIOD_MAX_DEF       = 70000;
  localparam int TICKS_PER_SECOND_DEF = 1000000;

  // shared multiply / divide unit widths
  localparam int MD_AW = 64;  // signed operand and result
  localparam int MD_BW = 28;  // signed multiplier, holds ticks per second
  localparam int MD_DW = 27;  // unsigned divisor
  localparam int MD_CW = $clog2(MD_AW);

  localparam logic [22:0] SPEED_CAP = 23'd4194304;

  // register indexes
  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_I     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_TARGET     = 3'd3;
  localparam logic [2:0] REG_BASE       = 3'd4;
  localparam logic [2:0] REG_GAP_MIN    = 3'd5;
  localparam logic [2:0] REG_GAP_MAX    = 3'd6;
  localparam logic [2:0] REG_CORR_LIMIT = 3'd7;

  typedef struct packed {
    logic start;
    logic nodiv;
  } md_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/slpid_muldiv.sv @@
`default_nettype none

// q = trunc(a * b / d), or a * b when nodiv is set
// shift-add multiply one bit per cycle, then restoring divide one bit per cycle
module slpid_muldiv (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire slpid_pkg::md_ctrl_t                    ctrl,
  input  wire logic signed [slpid_pkg::MD_AW-1:0]     a,
  input  wire logic signed [slpid_pkg::MD_BW-1:0]     b,
  input  wire logic        [slpid_pkg::MD_DW-1:0]     d,
  output logic                                        done,
  output logic signed [slpid_pkg::MD_AW-1:0]          q
);

  localparam int AW = slpid_pkg::MD_AW;
  localparam int BW = slpid_pkg::MD_BW;
  localparam int DW = slpid_pkg::MD_DW;
  localparam int CW = slpid_pkg::MD_CW;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIN} mstate_t;

  mstate_t         state;
  logic [AW-1:0]   am;
  logic [BW-1:0]   bm;
  logic [AW-1:0]   prod;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dr;
  logic            neg;
  logic            nodiv;
  logic [CW-1:0]   cnt;

  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW:0]     rem_sub;

  assign rem_sh  = {rem, prod[AW-1]};
  assign ge      = rem_sh >= {1'b0, dr};
  assign rem_sub = rem_sh - {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (ctrl.start) begin
            am    <= a[AW-1] ? AW'(-a) : AW'(a);
            bm    <= b[BW-1] ? BW'(-b) : BW'(b);
            neg   <= a[AW-1] ^ b[BW-1];
            nodiv <= ctrl.nodiv;
            dr    <= d;
            prod  <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          if (bm == '0) begin
            rem   <= '0;
            cnt   <= '0;
            state <= nodiv ? M_FIN : M_DIV;
          end else begin
            if (bm[0]) begin
              prod <= prod + am;
            end
            am <= am << 1;
            bm <= bm >> 1;
          end
        end
        M_DIV: begin
          rem  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          prod <= {prod[AW-2:0], ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(AW - 1)) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          q     <= neg ? $signed(AW'(-prod)) : $signed(prod);
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/slit_period_speed_pid_top.sv @@
`default_nettype none

// Slit period speed controller. Each input beat is a 16-bit capture timestamp;
// a capture below the previous one counts a timer wrap, and a gap from the
// previous capture strictly between gap_min and gap_max marks the reference
// slit. The first slit arms the block, each later one closes a period (ticks
// plus wraps times 65536). A period strictly inside PERIOD_MIN..PERIOD_MAX
// gives one output beat: speed in Q16.16, the period, and a PWM compare value
// from a PID step with Q8.8 gains. Beats that give no result are taken one per
// cycle. A beat that closes a valid period is slower: all multiplies and divisions
// run on one shared unit that multiplies one multiplier bit per cycle and divides
// one quotient bit per cycle (four divisions and seven multiplies per step), and no
// capture is taken until the step is done. The result waits in an output register,
// so the next capture is taken while it is still unread. Registers sit on an APB
// port, one 32-bit word each at byte address 4*index.
module slit_period_speed_pid_top #(
  parameter int PERIOD_MIN       = slpid_pkg::PERIOD_MIN_DEF,
  parameter int PERIOD_MAX       = slpid_pkg::PERIOD_MAX_DEF,
  parameter int TICKS_PER_SECOND = slpid_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // capture beats
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] capture_value,
  // result beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      compare_value,
  output logic [22:0]      measured_speed,
  output logic [16:0]      period_ticks
);

  localparam int AW = slpid_pkg::MD_AW;
  localparam int BW = slpid_pkg::MD_BW;
  localparam int DW = slpid_pkg::MD_DW;

  localparam logic signed [33:0]   PMIN_S  = 34'(PERIOD_MIN);
  localparam logic signed [33:0]   PMAX_S  = 34'(PERIOD_MAX);
  localparam logic signed [BW-1:0] TPS_B   = BW'(TICKS_PER_SECOND);
  localparam logic        [DW-1:0] TPS_D   = DW'(TICKS_PER_SECOND);
  localparam logic signed [AW-1:0] I32_MAX = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] I32_MIN = -AW'(64'sd2147483648);
  localparam logic signed [AW-1:0] I48_MAX = AW'(64'sd140737488355327);
  localparam logic signed [AW-1:0] I48_MIN = -AW'(64'sd140737488355328);
  localparam logic signed [AW-1:0] C46_MAX = AW'(64'sd35184372088831);
  localparam logic signed [AW-1:0] C46_MIN = -AW'(64'sd35184372088832);

  typedef enum logic [3:0] {
    S_IDLE, S_SPEED, S_DERIV, S_INTEG, S_MULP, S_MULI, S_MULD, S_CTRL, S_CORR, S_OUT
  } state_t;

  // configuration registers
  logic signed [15:0] gain_p, gain_i, gain_d;
  logic [22:0]        target_speed;
  logic [15:0]        base_pulse, gap_min, gap_max, correction_limit;

  // capture tracking
  logic [15:0] last_capture, wrap_count, start_capture, start_wraps;
  logic        armed;

  // controller state and work registers
  state_t             state;
  logic signed [47:0] error_integral;
  logic signed [24:0] previous_error;
  logic signed [24:0] err;
  logic signed [31:0] deriv;
  logic signed [AW-1:0] acc;
  logic [22:0]        speed;
  logic [16:0]        period;
  logic [15:0]        cmp;

  // shared multiply / divide unit
  slpid_pkg::md_ctrl_t   md_ctrl;
  logic signed [AW-1:0]  md_a;
  logic signed [BW-1:0]  md_b;
  logic        [DW-1:0]  md_d;
  logic                  md_done;
  logic signed [AW-1:0]  md_q;

  slpid_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (md_ctrl),
    .a    (md_a),
    .b    (md_b),
    .d    (md_d),
    .done (md_done),
    .q    (md_q)
  );

  // apb
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      slpid_pkg::REG_GAIN_P:     prdata = {16'b0, gain_p};
      slpid_pkg::REG_GAIN_I:     prdata = {16'b0, gain_i};
      slpid_pkg::REG_GAIN_D:     prdata = {16'b0, gain_d};
      slpid_pkg::REG_TARGET:     prdata = {9'b0, target_speed};
      slpid_pkg::REG_BASE:       prdata = {16'b0, base_pulse};
      slpid_pkg::REG_GAP_MIN:    prdata = {16'b0, gap_min};
      slpid_pkg::REG_GAP_MAX:    prdata = {16'b0, gap_max};
      slpid_pkg::REG_CORR_LIMIT: prdata = {16'b0, correction_limit};
      default:                   prdata = '0;
    endcase
  end

  // capture front end: wrap count, slit detection, period
  logic [15:0]        wrap_next;
  logic signed [17:0] gap;
  logic               slit;
  logic [15:0]        wrap_diff;
  logic signed [17:0] cap_diff;
  logic signed [33:0] period_full;
  logic               in_window;

  assign wrap_next   = (capture_value < last_capture) ? wrap_count + 16'd1 : wrap_count;
  assign gap         = $signed({2'b0, capture_value}) - $signed({2'b0, last_capture});
  assign slit        = (gap > $signed({2'b0, gap_min})) && (gap < $signed({2'b0, gap_max}));
  assign wrap_diff   = wrap_next - start_wraps;
  assign cap_diff    = $signed({2'b0, capture_value}) - $signed({2'b0, start_capture});
  assign period_full = $signed({2'b0, wrap_diff, 16'b0}) + 34'(cap_diff);
  assign in_window   = (period_full > PMIN_S) && (period_full < PMAX_S);

  assign in_ready = (state == S_IDLE);

  // speed saturation and error
  logic [22:0]        speed_c;
  logic signed [24:0] err_c;
  assign speed_c = (md_q > $signed(AW'(slpid_pkg::SPEED_CAP))) ? slpid_pkg::SPEED_CAP
                                                                : md_q[22:0];
  assign err_c   = $signed({2'b0, target_speed}) - $signed({2'b0, speed_c});

  // integral accumulate with saturation
  logic signed [AW-1:0] integ_sum;
  assign integ_sum = AW'(error_integral) + md_q;

  // sum / 256 toward zero, then clamp to 46 bits
  logic [AW-1:0]        acc_mag;
  logic [AW-1:0]        acc_sh;
  logic signed [AW-1:0] ctrl_t;
  logic signed [AW-1:0] ctrl_c;
  assign acc_mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign acc_sh  = acc_mag >> 8;
  assign ctrl_t  = acc[AW-1] ? $signed(AW'(-acc_sh)) : $signed(acc_sh);
  assign ctrl_c  = (ctrl_t > C46_MAX) ? C46_MAX : ((ctrl_t < C46_MIN) ? C46_MIN : ctrl_t);

  // correction clamp and compare value
  logic signed [AW-1:0] corr_lim;
  logic signed [AW-1:0] corr_c;
  logic signed [AW-1:0] total;
  logic [15:0]          cmp_c;
  assign corr_lim = $signed({32'b0, correction_limit, 16'b0});
  assign corr_c   = (md_q > corr_lim) ? corr_lim : md_q;
  assign total    = $signed({32'b0, base_pulse, 16'b0}) + corr_c;
  assign cmp_c    = total[AW-1] ? 16'd0 :
                    ((total[AW-1:32] != '0) ? 16'hFFFF : total[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= 16'sd256;
      gain_i           <= '0;
      gain_d           <= '0;
      target_speed     <= 23'd983040;
      base_pulse       <= 16'd2455;
      gap_min          <= 16'd700;
      gap_max          <= 16'd800;
      correction_limit <= 16'd500;
      last_capture     <= '0;
      wrap_count       <= '0;
      start_capture    <= '0;
      start_wraps      <= '0;
      armed            <= 1'b0;
      error_integral   <= '0;
      previous_error   <= '0;
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      md_ctrl          <= '0;
    end else begin
      md_ctrl <= '0;
      if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr) begin
        case (paddr[4:2])
          slpid_pkg::REG_GAIN_P:     gain_p           <= pwdata[15:0];
          slpid_pkg::REG_GAIN_I:     gain_i           <= pwdata[15:0];
          slpid_pkg::REG_GAIN_D:     gain_d           <= pwdata[15:0];
          slpid_pkg::REG_TARGET:     target_speed     <= pwdata[22:0];
          slpid_pkg::REG_BASE:       base_pulse       <= pwdata[15:0];
          slpid_pkg::REG_GAP_MIN:    gap_min          <= pwdata[15:0];
          slpid_pkg::REG_GAP_MAX:    gap_max          <= pwdata[15:0];
          slpid_pkg::REG_CORR_LIMIT: correction_limit <= pwdata[15:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_capture <= capture_value;
            wrap_count   <= wrap_next;
            if (slit) begin
              armed         <= 1'b1;
              start_capture <= capture_value;
              start_wraps   <= wrap_next;
              if (armed && in_window) begin
                // speed = ticks per second * 65536 / period
                period        <= period_full[16:0];
                md_ctrl.start <= 1'b1;
                md_a          <= AW'(65536);
                md_b          <= TPS_B;
                md_d          <= DW'(period_full[16:0]);
                state         <= S_SPEED;
              end
            end
          end
        end
        S_SPEED: begin
          if (md_done) begin
            speed         <= speed_c;
            err           <= err_c;
            md_ctrl.start <= 1'b1;
            md_a          <= AW'(err_c) - AW'(previous_error);
            md_b          <= TPS_B;
            md_d          <= DW'(period);
            state         <= S_DERIV;
          end
        end
        S_DERIV: begin
          if (md_done) begin
            deriv         <= (md_q > I32_MAX) ? 32'sh7FFFFFFF :
                             ((md_q < I32_MIN) ? 32'sh80000000 : md_q[31:0]);
            md_ctrl.start <= 1'b1;
            md_a          <= AW'(err);
            md_b          <= BW'($signed({1'b0, period}));
            md_d          <= TPS_D;
            state         <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (md_done) begin
            error_integral <= (integ_sum > I48_MAX) ? I48_MAX[47:0] :
                              ((integ_sum < I48_MIN) ? I48_MIN[47:0] : integ_sum[47:0]);
            previous_error <= err;
            md_ctrl.start  <= 1'b1;
            md_ctrl.nodiv  <= 1'b1;
            md_a           <= AW'(err);
            md_b           <= BW'(gain_p);
            state          <= S_MULP;
          end
        end
        S_MULP: begin
          if (md_done) begin
            acc           <= md_q;
            md_ctrl.start <= 1'b1;
            md_ctrl.nodiv <= 1'b1;
            md_a          <= AW'(error_integral);
            md_b          <= BW'(gain_i);
            state         <= S_MULI;
          end
        end
        S_MULI: begin
          if (md_done) begin
            acc           <= acc + md_q;
            md_ctrl.start <= 1'b1;
            md_ctrl.nodiv <= 1'b1;
            md_a          <= AW'(deriv);
            md_b          <= BW'(gain_d);
            state         <= S_MULD;
          end
        end
        S_MULD: begin
          if (md_done) begin
            acc   <= acc + md_q;
            state <= S_CTRL;
          end
        end
        S_CTRL: begin
          // correction = ctrl * period / ticks per second
          md_ctrl.start <= 1'b1;
          md_a          <= ctrl_c;
          md_b          <= BW'($signed({1'b0, period}));
          md_d          <= TPS_D;
          state         <= S_CORR;
        end
        S_CORR: begin
          if (md_done) begin
            cmp   <= cmp_c;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hand over once the output register is free
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            compare_value  <= cmp;
            measured_speed <= speed;
            period_ticks   <= period;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
